// ===== rtl/core/qdc_pkg.sv =====
// qdc_pkg: word and configuration types shared by the quadrature counter.
// No dependencies.
package qdc_pkg;

  localparam int HystWidth = 12;
  localparam int TickWidth = 32;
  localparam int AddrWidth = 3;
  localparam int DataWidth = 32;

  localparam logic RegReverse = 1'b0;
  localparam logic RegHyst    = 1'b1;

  localparam logic [HystWidth-1:0] HystReset = 12'd64;

  typedef struct packed {
    logic a_level;
    logic b_level;
    logic poll;
    logic ack_inc;
    logic ack_dec;
    logic clear_count;
  } sample_t;

  typedef struct packed {
    logic signed [TickWidth-1:0] tick_count;
    logic                        changed;
    logic                        incremented;
    logic                        decremented;
  } result_t;

  typedef struct packed {
    logic                 reverse;
    logic [HystWidth-1:0] hysteresis_ticks;
  } cfg_t;

endpackage

// ===== rtl/core/qdc_cfg.sv =====
// qdc_cfg: APB-style register bank for reverse and hysteresis_ticks.
// Depends on qdc_pkg.
module qdc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qdc_pkg::AddrWidth-1:0]    paddr,
  input  logic [qdc_pkg::DataWidth-1:0]    pwdata,
  output logic [qdc_pkg::DataWidth-1:0]    prdata,
  output logic                             pready,
  output qdc_pkg::cfg_t                    cfg
);
  import qdc_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reverse          <= 1'b0;
      cfg.hysteresis_ticks <= HystReset;
    end else if (wr) begin
      case (paddr[2])
        RegReverse: cfg.reverse          <= pwdata[0];
        RegHyst:    cfg.hysteresis_ticks <= pwdata[HystWidth-1:0];
        default:    cfg.reverse          <= cfg.reverse;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegReverse: prdata = {{(DataWidth-1){1'b0}}, cfg.reverse};
      RegHyst:    prdata = {{(DataWidth-HystWidth){1'b0}}, cfg.hysteresis_ticks};
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/qdc_core.sv =====
// qdc_core: input register, edge/count/poll logic with its state, result register.
// Depends on qdc_pkg.
module qdc_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  qdc_pkg::cfg_t    cfg,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  qdc_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output qdc_pkg::result_t result
);
  import qdc_pkg::*;

  localparam int CW   = COUNT_WIDTH;
  localparam int CMPW = (CW > HystWidth) ? CW : HystWidth;

  logic    hold_valid;
  sample_t hold;
  logic    move;

  logic          prev_a, prev_b, inc_flag, dec_flag;
  logic [CW-1:0] count, last_polled, last_mark;

  logic          rise_a, rise_b, up_a, up_b;
  logic [1:0]    n_up, n_dn;
  logic [2:0]    delta;
  logic [CW-1:0] cnt_e, cnt_c, lp_c, dd, mag;
  logic          diff, far, go_up, go_dn;
  logic          inc_p, dec_p;
  logic [CW-1:0] count_next, last_polled_next, last_mark_next;
  logic [TickWidth-1:0] tick;

  assign move         = hold_valid && (!result_valid || !result_stall);
  assign sample_stall = hold_valid && !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      hold_valid <= 1'b1;
    end else if (move) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      hold <= sample;
    end
  end

  always_comb begin
    rise_a = hold.a_level && !prev_a;
    rise_b = hold.b_level && !prev_b;
    up_a   = !hold.b_level ^ cfg.reverse;
    up_b   = hold.a_level ^ cfg.reverse;
    n_up   = {1'b0, rise_a && up_a} + {1'b0, rise_b && up_b};
    n_dn   = {1'b0, rise_a && !up_a} + {1'b0, rise_b && !up_b};
    delta  = {1'b0, n_up} - {1'b0, n_dn};
    cnt_e  = count + {{(CW-3){delta[2]}}, delta};
    cnt_c  = hold.clear_count ? '0 : cnt_e;
    lp_c   = hold.clear_count ? '0 : last_polled;
    diff   = hold.poll && (cnt_c != lp_c);
    dd     = last_mark - cnt_c;
    mag    = dd[CW-1] ? (~dd + 1'b1) : dd;
    far    = CMPW'(mag) >= CMPW'(cfg.hysteresis_ticks);
    go_up  = $signed(lp_c) < $signed(cnt_c);
    go_dn  = $signed(cnt_c) < $signed(lp_c);
    inc_p  = inc_flag;
    dec_p  = dec_flag;
    last_mark_next = last_mark;
    if (diff && far) begin
      if (go_up) begin
        inc_p = 1'b1;
        dec_p = 1'b0;
      end else if (go_dn) begin
        inc_p = 1'b0;
        dec_p = 1'b1;
      end
      last_mark_next = cnt_c;
    end
    last_polled_next = diff ? cnt_c : lp_c;
    count_next       = cnt_c;
  end

  generate
    if (CW >= TickWidth) begin : g_trunc
      assign tick = cnt_c[TickWidth-1:0];
    end else begin : g_ext
      assign tick = {{(TickWidth-CW){cnt_c[CW-1]}}, cnt_c};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a      <= 1'b0;
      prev_b      <= 1'b0;
      count       <= '0;
      last_polled <= '0;
      last_mark   <= '0;
      inc_flag    <= 1'b0;
      dec_flag    <= 1'b0;
    end else if (move) begin
      prev_a      <= hold.a_level;
      prev_b      <= hold.b_level;
      count       <= count_next;
      last_polled <= last_polled_next;
      last_mark   <= last_mark_next;
      inc_flag    <= inc_p && !hold.ack_inc;
      dec_flag    <= dec_p && !hold.ack_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result.tick_count  <= $signed(tick);
      result.changed     <= diff;
      result.incremented <= inc_p && !dec_p;
      result.decremented <= dec_p && !inc_p;
    end
  end

endmodule

// ===== rtl/core/quadrature_counter_with_direction_flags.sv =====
// Quadrature counter top level: register bank plus counting core.
// Depends on qdc_pkg, qdc_cfg, qdc_core.
//
//   channel  handshake                    word
//   sample   sample_valid / sample_stall  qdc_pkg::sample_t
//   result   result_valid / result_stall  qdc_pkg::result_t
//   config   psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One word per cycle sustained while results are not stalled; each sample goes
// via input register, then result register, and can leave at the next edge.
// Synchronous reset clears count, marks and flags, and resets the register bank.
// A stalled result holds; the input register still takes one more word,
// then sample_stall rises until the result drains.
module quadrature_counter_with_direction_flags #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  qdc_pkg::sample_t              sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output qdc_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qdc_pkg::AddrWidth-1:0] paddr,
  input  logic [qdc_pkg::DataWidth-1:0] pwdata,
  output logic [qdc_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import qdc_pkg::*;

  cfg_t cfg;

  qdc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qdc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.incremented && result.decremented))
    else $error("increment and decrement reported together");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall))
    else $error("sample stalled without a blocked result");

  a_reverse_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[2] == RegReverse) |=>
      cfg.reverse == $past(pwdata[0]))
    else $error("reverse register not written");

endmodule
